// ===== hw/rtl/polygon_star_vertex_generator_macros.svh =====
// assertion macros for the polygon and star vertex generator
`ifndef POLYGON_STAR_VERTEX_GENERATOR_MACROS_SVH
`define POLYGON_STAR_VERTEX_GENERATOR_MACROS_SVH
`ifndef SYNTH
// condition implies a consequence in the same cycle
`define PSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psv assertion failed");
// condition implies a consequence in the next cycle
`define PSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psv assertion failed");
`else
`define PSV_ASSERT_IMP(lbl, ante, cons)
`define PSV_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/psv_pkg.sv =====
// shared types, constants and tables of the polygon and star vertex generator
package psv_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 25;
  localparam int unsigned AngW   = 24;
  localparam int unsigned ZW     = 26;
  localparam int unsigned VecW   = 37;
  localparam int unsigned RotW   = 36;
  localparam int unsigned MW     = 6;
  localparam int unsigned SideW  = 5;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned StepW  = 5;
  localparam int unsigned MaxStep = 24;

  localparam logic [15:0] InvGain  = 16'd39797;
  localparam logic [15:0] RatioMin = 16'd3277;
  localparam logic [15:0] RatioMax = 16'd62259;
  localparam logic [SideW-1:0] SideMin = 5'd3;

  localparam logic signed [ZW-1:0] HalfTurn    = 26'sd8388608;
  localparam logic signed [ZW-1:0] QuarterTurn = 26'sd4194304;

  typedef enum logic [1:0] {
    CFG_SIDE_COUNT  = 2'd0,
    CFG_STAR_MODE   = 2'd1,
    CFG_INNER_RATIO = 2'd2,
    CFG_MIN_RADIUS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    F_IDLE, F_VEC, F_MLO, F_MHI, F_FIN
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV, B_SETUP, B_ROT, B_EMIT, B_CLOSE, B_REJ
  } back_state_e;

  // one classified shape handed from front to back
  typedef struct packed {
    logic                     rejected;
    logic                     star;
    logic [MW-1:0]            m;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [AngW-1:0]          start;
    logic [RadW-1:0]          outer;
    logic [RadW-1:0]          inner;
  } job_t;

  // atan(2^-i) in 2^-24 turns
  function automatic logic [AngW-1:0] atan_turn(input logic [StepW-1:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0:  v = 24'd2097152;
      5'd1:  v = 24'd1238021;
      5'd2:  v = 24'd654136;
      5'd3:  v = 24'd332050;
      5'd4:  v = 24'd166669;
      5'd5:  v = 24'd83416;
      5'd6:  v = 24'd41718;
      5'd7:  v = 24'd20860;
      5'd8:  v = 24'd10430;
      5'd9:  v = 24'd5215;
      5'd10: v = 24'd2608;
      5'd11: v = 24'd1304;
      5'd12: v = 24'd652;
      5'd13: v = 24'd326;
      5'd14: v = 24'd163;
      5'd15: v = 24'd81;
      5'd16: v = 24'd41;
      5'd17: v = 24'd20;
      5'd18: v = 24'd10;
      5'd19: v = 24'd5;
      5'd20: v = 24'd3;
      5'd21: v = 24'd1;
      5'd22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // clamp a 29-bit sum to the coordinate range
  function automatic logic signed [CoordW-1:0] sat24(input logic signed [28:0] v);
    logic signed [CoordW-1:0] r;
    if (v > 29'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -29'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/psv_queue.sv =====
// two-entry job queue between the front and the back
module psv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psv_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output psv_pkg::job_t pop_data_o,
  output logic          empty_o
);
  import psv_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/psv_front.sv =====
// front end: accepts a drag, measures radius and start angle, classifies it
module psv_front #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [psv_pkg::CoordW-1:0] centre_x_i,
  input  logic signed [psv_pkg::CoordW-1:0] centre_y_i,
  input  logic signed [psv_pkg::CoordW-1:0] drag_x_i,
  input  logic signed [psv_pkg::CoordW-1:0] drag_y_i,
  input  logic [psv_pkg::SideW-1:0]        side_count_i,
  input  logic                             star_mode_i,
  input  logic [15:0]                      inner_ratio_i,
  input  logic [15:0]                      min_radius_i,
  output logic                             push_o,
  output psv_pkg::job_t                    job_o,
  input  logic                             full_i
);
  import psv_pkg::*;

  localparam int unsigned NStep = (CORDIC_STEPS > MaxStep) ? MaxStep : CORDIC_STEPS;
  localparam logic [StepW-1:0] LastStep = StepW'(NStep - 1);

  front_state_e             state_q, state_d;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic signed [VecW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]     z_q;
  logic [StepW-1:0]         i_q;
  logic [53:0]              acc_q;
  logic [RadW-1:0]          outer_q;

  logic signed [24:0]     dx, dy;
  logic signed [VecW-1:0] x_init, y_init, xs, ys;
  logic signed [ZW-1:0]   at;
  logic [54:0]            rad_sum;
  logic [RadW-1:0]        outer_d;
  logic [41:0]            inner_full;
  logic                   accept;

  assign accept = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = state_q != F_IDLE;

  // drag vector scaled to the guard format
  assign dx = {drag_x_i[23], drag_x_i} - {centre_x_i[23], centre_x_i};
  assign dy = {drag_y_i[23], drag_y_i} - {centre_y_i[23], centre_y_i};
  assign x_init = $signed({{4{dx[24]}}, dx, 8'b0});
  assign y_init = $signed({{4{dy[24]}}, dy, 8'b0});

  // one vectoring step
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed({2'b00, atan_turn(i_q)});

  // radius scale by 1/K over two partial products
  assign rad_sum = {1'b0, acc_q} + {1'b0, 54'(x_q[35:18] * InvGain) << 18}
                 + 55'd8388608;
  assign outer_d = (rad_sum[54:24] > 31'h1FFFFFF) ? '1 : rad_sum[48:24];
  assign inner_full = 42'(outer_q * inner_ratio_i) + 42'd32768;

  // job leaving for the back
  always_comb begin
    job_o.rejected = outer_q < {9'd0, min_radius_i};
    job_o.star     = star_mode_i;
    job_o.m        = star_mode_i ? {side_count_i, 1'b0} : {1'b0, side_count_i};
    job_o.cx       = cx_q;
    job_o.cy       = cy_q;
    job_o.start    = z_q[AngW-1:0];
    job_o.outer    = outer_q;
    job_o.inner    = inner_full[40:16];
  end
  assign push_o = (state_q == F_FIN) && !full_i;

  // state sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (accept) state_d = F_VEC;
      F_VEC:  if (i_q == LastStep) state_d = F_MLO;
      F_MLO:  state_d = F_MHI;
      F_MHI:  state_d = F_FIN;
      F_FIN:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // vectoring datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        cx_q <= centre_x_i;
        cy_q <= centre_y_i;
        i_q  <= '0;
        if (dx[24]) begin
          x_q <= -x_init;
          y_q <= -y_init;
          z_q <= HalfTurn;
        end else begin
          x_q <= x_init;
          y_q <= y_init;
          z_q <= '0;
        end
      end
      F_VEC: begin
        i_q <= i_q + 5'd1;
        if (!y_q[VecW-1]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end
      end
      F_MLO: acc_q <= 54'(x_q[17:0] * InvGain);
      F_MHI: outer_q <= outer_d;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/psv_back.sv =====
// back end: steps the vertex angles, rotates each radius, tracks the box
module psv_back #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psv_pkg::job_t                     job_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [psv_pkg::CoordW-1:0] vertex_x_o,
  output logic signed [psv_pkg::CoordW-1:0] vertex_y_o,
  output logic                              last_vertex_o,
  output logic                              rejected_o,
  output logic signed [psv_pkg::CoordW-1:0] box_left_o,
  output logic signed [psv_pkg::CoordW-1:0] box_top_o,
  output logic signed [psv_pkg::CoordW-1:0] box_right_o,
  output logic signed [psv_pkg::CoordW-1:0] box_bottom_o
);
  import psv_pkg::*;

  localparam int unsigned NStep = (CORDIC_STEPS > MaxStep) ? MaxStep : CORDIC_STEPS;
  localparam logic [StepW-1:0] LastStep = StepW'(NStep - 1);
  localparam logic [StepW-1:0] DivLast  = StepW'(AngW);

  back_state_e              state_q, state_d;
  job_t                     job_q;
  logic [MW-1:0]            rem_q;
  logic [AngW-1:0]          quo_q, step_a_q, off_q;
  logic [StepW-1:0]         k_q, i_q;
  logic [MW-1:0]            step_b_q, offr_q, idx_q;
  logic signed [RotW-1:0]   x_q, y_q;
  logic signed [ZW-1:0]     z_q;
  logic                     flip_q;
  logic signed [CoordW-1:0] first_x_q, first_y_q;
  logic signed [CoordW-1:0] bl_q, bt_q, br_q, bb_q;
  logic                     out_valid_q;

  logic                   out_free, wr_out;
  logic [MW:0]            rem_sh, rem_d;
  logic                   ge;
  logic [MW:0]            offr_sum;
  logic [RadW-1:0]        r_sel;
  logic [40:0]            r_prod;
  logic [AngW-1:0]        angle;
  logic signed [ZW-1:0]   z0;
  logic signed [RotW-1:0] xs, ys, xr, yr;
  logic signed [ZW-1:0]   at;
  logic signed [27:0]     px, py;
  logic signed [CoordW-1:0] vx, vy;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign wr_out   = out_free && ((state_q == B_EMIT) || (state_q == B_CLOSE)
                                 || (state_q == B_REJ));

  // restoring divide of one full turn by the vertex count
  assign rem_sh = {rem_q, k_q == '0};
  assign ge     = rem_sh >= {1'b0, job_q.m};
  assign rem_d  = ge ? rem_sh - {1'b0, job_q.m} : rem_sh;

  // offset remainder step
  assign offr_sum = {1'b0, offr_q} + {1'b0, step_b_q};

  // rotation setup: radius prescaled by 1/K, angle folded to the right half
  assign r_sel  = (job_q.star && idx_q[0]) ? job_q.inner : job_q.outer;
  assign r_prod = 41'(r_sel * InvGain);
  assign angle  = job_q.start + off_q;
  assign z0     = $signed({{2{angle[AngW-1]}}, angle});

  // one rotation step
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed({2'b00, atan_turn(i_q)});

  // round, unfold and place on the centre
  assign xr = (x_q + 36'sd128) >>> 8;
  assign yr = (y_q + 36'sd128) >>> 8;
  assign px = flip_q ? -xr[27:0] : xr[27:0];
  assign py = flip_q ? -yr[27:0] : yr[27:0];
  assign vx = sat24({{5{job_q.cx[23]}}, job_q.cx} + {px[27], px});
  assign vy = sat24({{5{job_q.cy[23]}}, job_q.cy} + {py[27], py});

  // state sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!empty_i) state_d = job_i.rejected ? B_REJ : B_DIV;
      B_DIV:   if (k_q == DivLast) state_d = B_SETUP;
      B_SETUP: state_d = B_ROT;
      B_ROT:   if (i_q == LastStep) state_d = B_EMIT;
      B_EMIT: begin
        if (out_free) state_d = (idx_q == job_q.m - 6'd1) ? B_CLOSE : B_SETUP;
      end
      B_CLOSE: if (out_free) state_d = B_IDLE;
      B_REJ:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shape datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        job_q <= job_i;
        rem_q <= '0;
        quo_q <= '0;
        k_q   <= '0;
      end
      B_DIV: begin
        k_q   <= k_q + 5'd1;
        rem_q <= rem_d[MW-1:0];
        quo_q <= {quo_q[AngW-2:0], ge};
        if (k_q == DivLast) begin
          step_a_q <= {quo_q[AngW-2:0], ge};
          step_b_q <= rem_d[MW-1:0];
          off_q    <= '0;
          offr_q   <= job_q.m >> 1;
          idx_q    <= '0;
        end
      end
      B_SETUP: begin
        x_q <= $signed({3'b000, r_prod[40:8]});
        y_q <= '0;
        i_q <= '0;
        if (z0 > QuarterTurn) begin
          z_q    <= z0 - HalfTurn;
          flip_q <= 1'b1;
        end else if (z0 < -QuarterTurn) begin
          z_q    <= z0 + HalfTurn;
          flip_q <= 1'b1;
        end else begin
          z_q    <= z0;
          flip_q <= 1'b0;
        end
      end
      B_ROT: begin
        i_q <= i_q + 5'd1;
        if (!z_q[ZW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          idx_q <= idx_q + 6'd1;
          if (offr_sum >= {1'b0, job_q.m}) begin
            off_q  <= off_q + step_a_q + 24'd1;
            offr_q <= 6'(offr_sum - {1'b0, job_q.m});
          end else begin
            off_q  <= off_q + step_a_q;
            offr_q <= offr_sum[MW-1:0];
          end
          if (idx_q == '0) begin
            first_x_q <= vx;
            first_y_q <= vy;
            bl_q <= vx;
            br_q <= vx;
            bt_q <= vy;
            bb_q <= vy;
          end else begin
            if (vx < bl_q) bl_q <= vx;
            if (vx > br_q) br_q <= vx;
            if (vy < bt_q) bt_q <= vy;
            if (vy > bb_q) bb_q <= vy;
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (wr_out) begin
      case (state_q)
        B_EMIT: begin
          vertex_x_o    <= vx;
          vertex_y_o    <= vy;
          last_vertex_o <= 1'b0;
          rejected_o    <= 1'b0;
          box_left_o    <= '0;
          box_top_o     <= '0;
          box_right_o   <= '0;
          box_bottom_o  <= '0;
        end
        B_CLOSE: begin
          vertex_x_o    <= first_x_q;
          vertex_y_o    <= first_y_q;
          last_vertex_o <= 1'b1;
          rejected_o    <= 1'b0;
          box_left_o    <= bl_q;
          box_top_o     <= bt_q;
          box_right_o   <= br_q;
          box_bottom_o  <= bb_q;
        end
        default: begin
          vertex_x_o    <= '0;
          vertex_y_o    <= '0;
          last_vertex_o <= 1'b1;
          rejected_o    <= 1'b1;
          box_left_o    <= '0;
          box_top_o     <= '0;
          box_right_o   <= '0;
          box_bottom_o  <= '0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/polygon_star_vertex_generator.sv =====
// Polygon and star vertex generator, top level.
// Front: each drag runs the vectoring loop, two radius products and a hand-off to the queue.
// Back: a turn divide, then per vertex a setup, the rotation loop and an emit,
//   plus one closing transfer; a star at the default MAX_SIDES has up to 62 vertices.
// A rejected drag costs one transfer in the back. A two-entry queue decouples the halves.
// Reset is asynchronous, active low: control state clears, config registers return to defaults.
module polygon_star_vertex_generator #(
  parameter int unsigned MAX_SIDES    = 31,
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [psv_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [psv_pkg::CoordW-1:0] centre_x_i,
  input  logic signed [psv_pkg::CoordW-1:0] centre_y_i,
  input  logic signed [psv_pkg::CoordW-1:0] drag_x_i,
  input  logic signed [psv_pkg::CoordW-1:0] drag_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [psv_pkg::CoordW-1:0] vertex_x_o,
  output logic signed [psv_pkg::CoordW-1:0] vertex_y_o,
  output logic                              last_vertex_o,
  output logic                              rejected_o,
  output logic signed [psv_pkg::CoordW-1:0] box_left_o,
  output logic signed [psv_pkg::CoordW-1:0] box_top_o,
  output logic signed [psv_pkg::CoordW-1:0] box_right_o,
  output logic signed [psv_pkg::CoordW-1:0] box_bottom_o
);
  import psv_pkg::*;

`include "polygon_star_vertex_generator_macros.svh"

  localparam logic [SideW-1:0] SideMax = SideW'(MAX_SIDES);

  logic [SideW-1:0] side_count_q;
  logic             star_mode_q;
  logic [15:0]      inner_ratio_q, min_radius_q;
  logic [SideW-1:0] side_wr;
  logic [15:0]      ratio_wr;

  logic push, pop, full, empty;
  job_t push_job, pop_job;

  // saturate side count and inner ratio register writes
  assign side_wr = (cfg_data_i[4:0] < SideMin) ? SideMin :
                   (cfg_data_i[4:0] > SideMax) ? SideMax : cfg_data_i[4:0];
  assign ratio_wr = (cfg_data_i < RatioMin) ? RatioMin :
                    (cfg_data_i > RatioMax) ? RatioMax : cfg_data_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_count_q  <= 5'd5;
      star_mode_q   <= 1'b0;
      inner_ratio_q <= 16'd32768;
      min_radius_q  <= 16'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIDE_COUNT:  side_count_q  <= side_wr;
        CFG_STAR_MODE:   star_mode_q   <= cfg_data_i[0];
        CFG_INNER_RATIO: inner_ratio_q <= ratio_wr;
        CFG_MIN_RADIUS:  min_radius_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psv_front #(.CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .centre_x_i   (centre_x_i),
    .centre_y_i   (centre_y_i),
    .drag_x_i     (drag_x_i),
    .drag_y_i     (drag_y_i),
    .side_count_i (side_count_q),
    .star_mode_i  (star_mode_q),
    .inner_ratio_i(inner_ratio_q),
    .min_radius_i (min_radius_q),
    .push_o       (push),
    .job_o        (push_job),
    .full_i       (full)
  );

  psv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_job),
    .empty_o    (empty)
  );

  psv_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (pop_job),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .vertex_x_o   (vertex_x_o),
    .vertex_y_o   (vertex_y_o),
    .last_vertex_o(last_vertex_o),
    .rejected_o   (rejected_o),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_right_o  (box_right_o),
    .box_bottom_o (box_bottom_o)
  );

  // a rejection is a single closing result with no coordinates
  `PSV_ASSERT_IMP(a_rej_closes, out_valid_o && rejected_o, last_vertex_o && (vertex_x_o == '0) && (box_left_o == '0))
  // the box only travels with the closing result
  `PSV_ASSERT_IMP(a_box_only_last, out_valid_o && !last_vertex_o, (box_left_o == '0) && (box_right_o == '0) && (box_top_o == '0) && (box_bottom_o == '0))
  // the box on a real shape is ordered
  `PSV_ASSERT_IMP(a_box_order, out_valid_o && last_vertex_o && !rejected_o, (box_left_o <= box_right_o) && (box_top_o <= box_bottom_o))
  // the front is busy right after taking a drag
  `PSV_ASSERT_NXT(a_front_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule
